[hdl/ole_pkg.sv]
package ole_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE_POS = 3'd2,
        CMD_REMOVE_VAL = 3'd3,
        CMD_READ       = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic [4:0]         entry_count;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl_cmd;

endpackage

[hdl/ole_ctrl.sv]
module ole_ctrl import ole_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output logic     o_valid,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_EXEC);
        end
    end

    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign busy       = (r_state != S_IDLE);
    assign o_valid    = r_strobe;

endmodule

[hdl/ole_dp.sv]
module ole_dp import ole_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl_cmd  i_cmd,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic [31:0]      r_cells [DEPTH];
    logic [31:0]      n_cells [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_in_word         r_in;
    t_out_word        r_out;
    t_out_word        n_out;

    logic [DEPTH-1:0] match;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] rm_idx;
    logic [31:0]      rd_data;
    logic             is_full;
    logic             is_empty;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             do_ins;
    logic             do_rm;

    // compare all live cells against the search value, lowest index wins
    always_comb begin
        match_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (32'(i) < 32'(r_count)) && (r_cells[i] == r_in.value);
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                match_idx = IDX_W'(i);
            end
        end
    end

    assign is_full    = (32'(r_count) >= 32'(DEPTH));
    assign is_empty   = (r_count == '0);
    assign pos_gt_cnt = (32'(r_in.position) > 32'(r_count));
    assign pos_ge_cnt = (32'(r_in.position) >= 32'(r_count));
    assign ins_idx    = (r_in.cmd == CMD_APPEND) ? r_count[IDX_W-1:0]
                                                 : r_in.position[IDX_W-1:0];
    assign rm_idx     = (r_in.cmd == CMD_REMOVE_VAL) ? match_idx
                                                     : r_in.position[IDX_W-1:0];
    assign rd_data    = r_cells[rm_idx];

    always_comb begin
        do_ins            = 1'b0;
        do_rm             = 1'b0;
        n_out.status      = ST_OK;
        n_out.item_value  = '0;
        unique case (r_in.cmd)
            CMD_APPEND: begin
                if (is_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_gt_cnt) begin
                    n_out.status = ST_RANGE;
                end else if (is_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            CMD_REMOVE_POS, CMD_READ: begin
                if (is_empty) begin
                    n_out.status = ST_EMPTY;
                end else if (pos_ge_cnt) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.item_value = rd_data;
                    do_rm            = (r_in.cmd == CMD_REMOVE_POS);
                end
            end
            CMD_REMOVE_VAL: begin
                if (is_empty) begin
                    n_out.status = ST_EMPTY;
                end else if (!(|match)) begin
                    n_out.status = ST_NOTFOUND;
                end else begin
                    n_out.item_value = rd_data;
                    do_rm            = 1'b1;
                end
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rm) begin
            n_count = r_count - CNT_W'(1);
        end
        n_out.entry_count = 5'(n_count);
    end

    // one step of the shift row: open a gap on insert, close one on remove
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            if (do_ins) begin
                if (32'(i) == 32'(ins_idx)) begin
                    n_cells[i] = r_in.value;
                end else if (32'(i) > 32'(ins_idx)) begin
                    n_cells[i] = r_cells[(i == 0) ? 0 : i - 1];
                end
            end else if (do_rm) begin
                if (32'(i) >= 32'(rm_idx)) begin
                    n_cells[i] = r_cells[(i == DEPTH - 1) ? i : i + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_word;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
            for (int i = 0; i < DEPTH; i++) begin
                r_cells[i] <= n_cells[i];
            end
        end
    end

    assign o_result = r_out;

endmodule

[hdl/ordered_list_engine.sv]
// Channel   Ports                   Handshake
// command   i_word (t_in_word)      taken when start && !busy
// result    o_result (t_out_word)   one cycle wide, marked by o_valid
//
// Each command passes through an accept cycle and an execute cycle in which
// the compare, priority select and one shift of the 16-cell register row all
// settle. The result appears with o_valid the cycle after execute, when the
// engine is already idle and can take the next word.
// Synchronous active-low reset empties the list; cell contents are not cleared.
// The receiver cannot stall: o_valid lasts one cycle.
module ordered_list_engine import ole_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_word,
    output logic      busy,
    output logic      o_valid,
    output t_out_word o_result
);

    t_ctl_cmd ctl_cmd;

    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (ctl_cmd)
    );

    ole_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ctl_cmd),
        .i_word   (i_word),
        .o_result (o_result)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && !busy)
        else $error("execute cycle not followed by a result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_result.entry_count) <= 32'(DEPTH))
        else $error("entry count beyond list depth");

endmodule

[sim/ordered_list_engine_tb.sv]
module ordered_list_engine_tb import ole_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         PHASE_WORDS     = 576;
    localparam int         STALL_LIMIT     = 5000;
    localparam int         TAIL_CYCLES     = 8;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      cmd_start = 1'b0;
    t_in_word  cmd_word = '0;
    logic      busy;
    logic      o_valid;
    t_out_word o_result;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    logic signed [31:0] list_mem [DEPTH];
    int                 list_len = 0;

    int sender_idle_pct = 0;
    int fail_count = 0;
    int quiet_cycles = 0;

    ordered_list_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (cmd_start),
        .i_word  (cmd_word),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    function automatic void list_drop(int at);
        for (int i = at; i + 1 < list_len; i++) begin
            list_mem[i] = list_mem[i + 1];
        end
        list_len--;
    endfunction

    function automatic t_out_word list_apply(t_in_word w);
        t_out_word r;
        int        pos;
        int        hit;
        r        = '0;
        r.status = ST_OK;
        pos      = w.position;
        hit      = -1;
        case (w.cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len] = w.value;
                    list_len++;
                end
            end
            CMD_INSERT: begin
                if (pos > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > pos; i--) begin
                        list_mem[i] = list_mem[i - 1];
                    end
                    list_mem[pos] = w.value;
                    list_len++;
                end
            end
            CMD_REMOVE_POS: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.item_value = list_mem[pos];
                    list_drop(pos);
                end
            end
            CMD_REMOVE_VAL: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_len && hit < 0; i++) begin
                        if (list_mem[i] == w.value) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        r.item_value = list_mem[hit];
                        list_drop(hit);
                    end
                end
            end
            CMD_READ: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.item_value = list_mem[pos];
                end
            end
            default: ;
        endcase
        r.entry_count = 5'(list_len);
        return r;
    endfunction

    // driver: one word presented at a time, held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_start <= 1'b0;
        end else if (!cmd_start || !busy) begin
            if (cmd_start) begin
                expected_results.push_back(list_apply(cmd_word));
            end
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                cmd_start <= 1'b1;
                cmd_word  <= pending_words.pop_front();
            end else begin
                cmd_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual st=%0d val=%h cnt=%0d",
                         $time, o_result.status, o_result.item_value, o_result.entry_count);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    fail_count++;
                end
                if (o_result.item_value !== want.item_value) begin
                    $display("%0t: item_value expected %h actual %h",
                             $time, want.item_value, o_result.item_value);
                    fail_count++;
                end
                if (o_result.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, o_result.entry_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((cmd_start && !busy) || o_valid) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in_word make_word(logic [2:0] cmd, int pos, logic signed [31:0] val);
        t_in_word w;
        w.cmd      = cmd;
        w.position = 5'(pos);
        w.value    = val;
        return w;
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 32'($urandom_range(0, 7)) - 32'sd4;
        if (r < 65) return 32'sh8000_0000;
        if (r < 70) return 32'sh7fff_ffff;
        return $urandom;
    endfunction

    function automatic t_in_word pick_word(logic grow);
        int         r;
        int         pos;
        logic [2:0] cmd;
        r   = $urandom_range(0, 99);
        pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 16);
        if (grow) begin
            cmd = (r < 45) ? CMD_APPEND : (r < 85) ? CMD_INSERT : (r < 90) ? CMD_REMOVE_POS :
                  (r < 95) ? CMD_REMOVE_VAL : (r < 98) ? CMD_READ : CMD_SPARE_FIRST;
        end else begin
            cmd = (r < 10) ? CMD_APPEND : (r < 15) ? CMD_INSERT : (r < 50) ? CMD_REMOVE_POS :
                  (r < 80) ? CMD_REMOVE_VAL : (r < 95) ? CMD_READ : CMD_SPARE_FIRST;
        end
        if (cmd == CMD_SPARE_FIRST) cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        return make_word(cmd, pos, pick_value());
    endfunction

    task automatic fill_random(int n);
        int   burst;
        logic grow;
        grow  = 1'b1;
        burst = 0;
        for (int k = 0; k < n; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(10, 40);
                grow  = ~grow;
            end
            burst--;
            pending_words.push_back(pick_word(grow));
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || cmd_start || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 21;
        pending_words.push_back(make_word(CMD_READ, 0, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_POS, 0, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_VAL, 0, 32'sd5));
        pending_words.push_back(make_word(CMD_SPARE_FIRST, 3, 32'sd9));
        pending_words.push_back(make_word(CMD_SPARE_LAST, 0, 32'sd0));
        pending_words.push_back(make_word(CMD_APPEND, 0, 32'sh8000_0000));
        pending_words.push_back(make_word(CMD_APPEND, 0, 32'sh7fff_ffff));
        pending_words.push_back(make_word(CMD_APPEND, 0, -32'sd1));
        pending_words.push_back(make_word(CMD_INSERT, 0, 32'sd7));
        pending_words.push_back(make_word(CMD_INSERT, 4, 32'sd7));
        pending_words.push_back(make_word(CMD_INSERT, 6, 32'sd1));
        pending_words.push_back(make_word(CMD_INSERT, 31, 32'sd1));
        pending_words.push_back(make_word(CMD_READ, 4, 32'sd0));
        pending_words.push_back(make_word(CMD_READ, 5, 32'sd0));
        pending_words.push_back(make_word(CMD_READ, 31, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_VAL, 0, 32'sd7));
        pending_words.push_back(make_word(CMD_REMOVE_VAL, 0, 32'sd12345));
        pending_words.push_back(make_word(CMD_REMOVE_POS, 4, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_POS, 1, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_POS, 0, 32'sd0));
        pending_words.push_back(make_word(CMD_READ, 0, 32'sd0));
        pending_words.push_back(make_word(CMD_REMOVE_VAL, 0, -32'sd1));
        pending_words.push_back(make_word(CMD_SPARE_LAST - 3'd1, 31, -32'sd1));
        pending_words.push_back(make_word(CMD_REMOVE_POS, 0, 32'sd0));
        fill_random(PHASE_WORDS);
        drain();

        sender_idle_pct = 78;
        fill_random(PHASE_WORDS);
        drain();

        sender_idle_pct = 0;
        fill_random(PHASE_WORDS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
